### hdl/ssm_pkg.sv
// Shared types, constants and helpers for the segmented stochastic multiplier.
// No dependencies; used by ssm_operand_split and the top level.
package ssm_pkg;

  // Operand and segmentation geometry
  localparam int unsigned WordBits   = 20;
  localparam int unsigned LowBits    = 10;
  localparam int unsigned ProdBits   = 21;
  localparam int unsigned CountShift = 11;

  // Sign and magnitude of one operand; magnitude of the most negative value is exact
  typedef struct packed {
    logic                neg;
    logic [WordBits-1:0] mag;
  } opd_t;

  // Ones in the AND of an evenly spread stream and a leading-ones stream,
  // taken from the registered product h*(2l+1): floor((p-1)/2048), zero for p = 0
  function automatic logic [ProdBits-CountShift-1:0] cross_count(
    input logic [ProdBits-1:0] prod
  );
    logic [ProdBits-1:0] dec;
    dec = prod - ProdBits'(1);
    if (prod == '0) begin
      return '0;
    end
    return dec[ProdBits-1:CountShift];
  endfunction

endpackage

### hdl/ssm_operand_split.sv
// Sign and magnitude extraction for one two's-complement operand.
// Depends on ssm_pkg for the operand width and the opd_t struct.
module ssm_operand_split (
  input  logic [ssm_pkg::WordBits-1:0] raw_i,
  output ssm_pkg::opd_t                opd_o
);

  logic sign;

  // Take the sign bit, negate when set
  assign sign       = raw_i[ssm_pkg::WordBits-1];
  assign opd_o.neg  = sign;
  assign opd_o.mag  = sign ? (~raw_i + ssm_pkg::WordBits'(1)) : raw_i;

endmodule

### hdl/segmented_stochastic_multiplier_top.sv
// Top level of the segmented stochastic multiplier: three register stages.
// Depends on ssm_pkg and ssm_operand_split.
//
// Usage:
//   Drive left_operand_i and right_operand_i with two 20-bit two's-complement
//   words and raise start for one cycle; the beat is taken at that clock edge.
//   busy is tied low, so a new operand pair may be given in every cycle.
//   After the beat passes the product and result registers, done_o is
//   high for exactly one cycle with product_estimate_o, a 21-bit signed
//   estimate of roughly left * right / 2^19. Results leave in the order
//   the operands arrived. Throughput: one operand pair per cycle; the
//   pipeline is input register, product register (three multipliers of
//   up to 11x11 bits), result register (count, sum and sign).
//   Reset (rst_ni low) clears the valid bits at once; no result is given
//   for beats in flight. The receiver cannot stall: each result shows for
//   one cycle only.
module segmented_stochastic_multiplier_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ssm_pkg::WordBits-1:0] left_operand_i,
  input  logic [ssm_pkg::WordBits-1:0] right_operand_i,
  output logic                         done_o,
  output logic signed [ssm_pkg::ProdBits-1:0] product_estimate_o
);

  localparam int unsigned WB = ssm_pkg::WordBits;
  localparam int unsigned LB = ssm_pkg::LowBits;
  localparam int unsigned PB = ssm_pkg::ProdBits;
  localparam int unsigned CB = ssm_pkg::ProdBits - ssm_pkg::CountShift;

  // Input register
  logic          in_vld_q;
  logic [WB-1:0] lhs_q, rhs_q;

  // Product register
  logic          p2_vld_q, p2_neg_q;
  logic [PB-1:0] p2_hh_q, p2_cl_q, p2_cr_q;

  // Result register
  logic          out_vld_q;
  logic [PB-1:0] res_q;

  ssm_pkg::opd_t lhs_opd, rhs_opd;
  logic [WB:0]   b_mag;
  logic [WB-LB-1:0] ah;
  logic [LB-1:0]    al, bl;
  logic [WB-LB:0]   bh;
  logic [PB:0]      hh_full, cl_full, cr_full;
  logic [CB-1:0]    cnt_l, cnt_r;
  logic [PB-1:0]    mag_d, res_d;

  assign busy = 1'b0;

  // Capture the operand beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      lhs_q <= left_operand_i;
      rhs_q <= right_operand_i;
    end
  end

  ssm_operand_split u_split_lhs (
    .raw_i (lhs_q),
    .opd_o (lhs_opd)
  );

  ssm_operand_split u_split_rhs (
    .raw_i (rhs_q),
    .opd_o (rhs_opd)
  );

  // Split a = |lhs| and b = 2|rhs| into high and low segments
  assign b_mag = {rhs_opd.mag, 1'b0};
  assign ah    = lhs_opd.mag[WB-1:LB];
  assign al    = lhs_opd.mag[LB-1:0];
  assign bh    = b_mag[WB:LB];
  assign bl    = b_mag[LB-1:0];

  // High product and the two cross-term products h*(2l+1)
  assign hh_full = (PB+1)'(ah) * (PB+1)'(bh);
  assign cl_full = (PB+1)'(ah) * (PB+1)'({bl, 1'b1});
  assign cr_full = (PB+1)'(bh) * (PB+1)'({al, 1'b1});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      p2_neg_q <= lhs_opd.neg ^ rhs_opd.neg;
      p2_hh_q  <= hh_full[PB-1:0];
      p2_cl_q  <= cl_full[PB-1:0];
      p2_cr_q  <= cr_full[PB-1:0];
    end
  end

  // Turn products into stream counts, sum and apply the sign
  assign cnt_l = ssm_pkg::cross_count(p2_cl_q);
  assign cnt_r = ssm_pkg::cross_count(p2_cr_q);
  assign mag_d = p2_hh_q + PB'(cnt_l) + PB'(cnt_r);
  assign res_d = p2_neg_q ? (PB'(0) - mag_d) : mag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o             = out_vld_q;
  assign product_estimate_o = $signed(res_q);

  // Every accepted beat is taken as a result once it has passed the product and result registers
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##3 done_o)
    else $error("accepted beat did not produce a result");

  // No result without a beat in the product stage
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(p2_vld_q))
    else $error("result strobe without a beat behind it");

  // Matching signs give a non-negative estimate
  a_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q && !p2_neg_q |=> !product_estimate_o[PB-1])
    else $error("negative estimate from operands of equal sign");

  // Magnitude stays within 2^19 + 2^10 + 2^9
  a_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q |-> mag_d <= PB'(525824))
    else $error("product magnitude out of range");

endmodule

### bench/tb.sv
// Self-checking bench for segmented_stochastic_multiplier_top: directed then random beats.
// Depends on ssm_pkg and the RTL; a scoreboard class predicts every product estimate.
`timescale 1ns / 100ps

module tb;
  localparam int unsigned WordBits = ssm_pkg::WordBits;
  localparam int unsigned LowBits  = ssm_pkg::LowBits;
  localparam int unsigned ProdBits = ssm_pkg::ProdBits;

  localparam int unsigned RandomBeats = 1900;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePercent = 34;

  // Predicts product estimates and holds those still due from the block
  class product_scoreboard;
    logic [ProdBits-1:0] expected_products[$];
    int unsigned         mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Ones in the AND of an evenly spread h-stream and a leading l-stream
    function int unsigned stream_overlap(int unsigned h, int unsigned l);
      int unsigned prod;
      prod = h * (2 * l + 1);
      if (prod == 0) begin
        return 0;
      end
      return (prod - 1) / (2 ** (LowBits + 1));
    endfunction

    function logic [ProdBits-1:0] predict_product(logic [WordBits-1:0] lhs,
                                                  logic [WordBits-1:0] rhs);
      logic                neg_l;
      logic                neg_r;
      logic [WordBits-1:0] mag_l;
      logic [WordBits-1:0] mag_r;
      int unsigned         a;
      int unsigned         b;
      int unsigned         low_mask;
      int unsigned         total;
      neg_l = lhs[WordBits-1];
      neg_r = rhs[WordBits-1];
      // the most negative word gives 2^19, which still fits the field
      mag_l = neg_l ? WordBits'(0) - lhs : lhs;
      mag_r = neg_r ? WordBits'(0) - rhs : rhs;
      a = mag_l;
      b = int'(mag_r) << 1;
      low_mask = (1 << LowBits) - 1;
      total = (a >> LowBits) * (b >> LowBits)
            + stream_overlap(a >> LowBits, b & low_mask)
            + stream_overlap(b >> LowBits, a & low_mask);
      if (neg_l != neg_r) begin
        total = 0 - total;
      end
      return ProdBits'(total);
    endfunction

    function void note_operands(logic [WordBits-1:0] lhs, logic [WordBits-1:0] rhs);
      expected_products.push_back(predict_product(lhs, rhs));
    endfunction

    task check_product(logic [ProdBits-1:0] got);
      logic [ProdBits-1:0] want;
      if (expected_products.size() == 0) begin
        report($sformatf("unexpected product %0d", $signed(got)));
      end else begin
        want = expected_products.pop_front();
        if (got !== want) begin
          report($sformatf("product_estimate %0d, predicted %0d",
                           $signed(got), $signed(want)));
        end
      end
    endtask

    function int unsigned pending();
      return expected_products.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [WordBits-1:0]        left_operand_i;
  logic [WordBits-1:0]        right_operand_i;
  logic                       done_o;
  logic signed [ProdBits-1:0] product_estimate_o;

  product_scoreboard sb = new();
  int unsigned       quiet_cycles;

  segmented_stochastic_multiplier_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .left_operand_i     (left_operand_i),
    .right_operand_i    (right_operand_i),
    .done_o             (done_o),
    .product_estimate_o (product_estimate_o)
  );

  // Clock: 20 ns period
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Monitor: check results, note accepted beats, guard against a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_product(product_estimate_o);
      end
      if (start && !busy) begin
        sb.note_operands(left_operand_i, right_operand_i);
      end
      if (done_o || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Offer one beat, optionally after random idle cycles, and hold until taken
  task automatic drive_beat(logic [WordBits-1:0] lhs, logic [WordBits-1:0] rhs,
                            bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < IdlePercent) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start           <= 1'b1;
    left_operand_i  <= lhs;
    right_operand_i <= rhs;
    do begin
      @(posedge clk_i);
    end while (busy);
  endtask

  // Drop start and hold until every predicted product has come back
  task automatic drain_products();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random operand: mostly full words, with small, extreme and split-edge values
  function automatic logic [WordBits-1:0] pick_operand();
    logic [WordBits-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = WordBits'($urandom);
      5: begin
        v = WordBits'($urandom_range((1 << LowBits) - 1));
        if ($urandom_range(1)) begin
          v = WordBits'(0) - v;
        end
      end
      6: begin
        case ($urandom_range(7))
          0: v = '0;
          1: v = WordBits'(1);
          2: v = {1'b0, {(WordBits-1){1'b1}}};
          3: v = {1'b1, {(WordBits-1){1'b0}}};
          4: v = {1'b1, {(WordBits-2){1'b0}}, 1'b1};
          5: v = '1;
          6: v = WordBits'((1 << LowBits) - 1);
          default: v = WordBits'(1 << LowBits);
        endcase
      end
      7: v = WordBits'($urandom) & ~WordBits'((1 << LowBits) - 1);
      8: v = WordBits'($urandom) | WordBits'((1 << LowBits) - 1);
      default: v = WordBits'($urandom) & WordBits'((1 << (LowBits + 2)) - 1);
    endcase
    return v;
  endfunction

  localparam logic [WordBits-1:0] MaxPos = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] MinNeg = {1'b1, {(WordBits-1){1'b0}}};
  localparam logic [WordBits-1:0] MinusOne = '1;

  localparam int unsigned DirectedBeats = 22;
  logic [WordBits-1:0] directed_lhs [DirectedBeats] = '{
    '0, MaxPos, MinNeg, MinNeg, MaxPos, MinusOne, MinNeg, MaxPos,
    // zero magnitude against a negative operand
    '0, MinNeg,
    // zero high part: small values on one or both sides
    20'h003FF, 20'h00001, 20'hFFC01, 20'h00400, 20'h003FF,
    20'h12345, 20'hEDCBA, 20'h40000, 20'hC0000, 20'h7FC00, 20'h803FF, 20'h55555
  };
  logic [WordBits-1:0] directed_rhs [DirectedBeats] = '{
    '0, MaxPos, MinNeg, MaxPos, MinNeg, MinusOne, MinusOne, MinusOne,
    MinusOne, '0,
    20'h003FF, 20'h7FFFF, 20'h00200, 20'h001FF, 20'h80000,
    20'h0ABCD, 20'h54321, 20'h40000, 20'h40000, 20'h003FF, 20'hFFE00, 20'hAAAAA
  };

  // Stimulus
  initial begin
    bit may_idle;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    left_operand_i  = '0;
    right_operand_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats
    for (int i = 0; i < DirectedBeats; i++) begin
      drive_beat(directed_lhs[i], directed_rhs[i], 1'b1);
    end
    drain_products();

    // random beats, one long stretch back to back, two full drains on the way
    for (int i = 0; i < RandomBeats; i++) begin
      if (i == 400 || i == 1400) begin
        drain_products();
      end
      may_idle = !(i >= 700 && i < 1000);
      drive_beat(pick_operand(), pick_operand(), may_idle);
    end
    start <= 1'b0;

    // wait out the pipeline, then judge
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d predicted products never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
